// ----- design/forth_stack_machine_core_top_assert.svh -----
// assertion macros for the forth stack machine core
`ifndef FORTH_STACK_MACHINE_CORE_TOP_ASSERT_SVH
`define FORTH_STACK_MACHINE_CORE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FSMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FSMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fsmc_pkg.sv -----
// shared types and codes for the forth stack machine core
`default_nettype none

package fsmc_pkg;

  // token codes
  localparam logic [4:0] OP_PUSH = 5'd0;
  localparam logic [4:0] OP_CR   = 5'd1;
  localparam logic [4:0] OP_DOT  = 5'd2;
  localparam logic [4:0] OP_IF   = 5'd3;
  localparam logic [4:0] OP_ELSE = 5'd4;
  localparam logic [4:0] OP_THEN = 5'd5;
  localparam logic [4:0] OP_DUP  = 5'd6;
  localparam logic [4:0] OP_DROP = 5'd7;
  localparam logic [4:0] OP_ADD  = 5'd8;
  localparam logic [4:0] OP_SUB  = 5'd9;
  localparam logic [4:0] OP_MUL  = 5'd10;
  localparam logic [4:0] OP_DIV  = 5'd11;
  localparam logic [4:0] OP_MOD  = 5'd12;
  localparam logic [4:0] OP_SWAP = 5'd13;
  localparam logic [4:0] OP_GT   = 5'd14;
  localparam logic [4:0] OP_LT   = 5'd15;
  localparam logic [4:0] OP_GE   = 5'd16;
  localparam logic [4:0] OP_LE   = 5'd17;
  localparam logic [4:0] OP_EQ   = 5'd18;
  localparam logic [4:0] OP_NE   = 5'd19;
  localparam logic [4:0] OP_ZGT  = 5'd20;
  localparam logic [4:0] OP_ZLT  = 5'd21;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ  = 3'd3;
  localparam logic [2:0] ERR_UNDEF = 3'd4;

  // stream widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 80;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_LOAD = 2'd3
  } cell_cmd_e;

  typedef enum logic [1:0] {
    SKIP_NONE = 2'd0,
    SKIP_IF   = 2'd1,
    SKIP_ELSE = 2'd2
  } skip_e;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_MOD = 2'd2
  } alu_kind_e;

  typedef struct packed {
    logic      start;
    alu_kind_e kind;
  } alu_req_t;

  typedef struct packed {
    cell_cmd_e head;
    cell_cmd_e second;
    cell_cmd_e rest;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/fsmc_stack_cell.sv -----
// one entry of the shifting data stack
`default_nettype none

module fsmc_stack_cell #(
  parameter int WORD_WIDTH = 32
) (
  input  wire                   clk_i,
  input  wire fsmc_pkg::cell_cmd_e cmd_i,
  input  wire  [WORD_WIDTH-1:0] up_i,
  input  wire  [WORD_WIDTH-1:0] down_i,
  input  wire  [WORD_WIDTH-1:0] load_i,
  output logic [WORD_WIDTH-1:0] value_o
);
  import fsmc_pkg::*;

  logic [WORD_WIDTH-1:0] value_q;

  // push takes the entry above, pop the entry below
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CELL_PUSH: value_q <= up_i;
      CELL_POP:  value_q <= down_i;
      CELL_LOAD: value_q <= load_i;
      default:   value_q <= value_q;
    endcase
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- design/fsmc_serial_alu.sv -----
// bit-serial multiply and signed divide / modulo unit
`default_nettype none

module fsmc_serial_alu #(
  parameter int WORD_WIDTH = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire fsmc_pkg::alu_req_t req_i,
  input  wire  [WORD_WIDTH-1:0] opa_i,   // top of stack
  input  wire  [WORD_WIDTH-1:0] opb_i,   // second entry
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] result_o
);
  import fsmc_pkg::*;

  localparam int CntW = $clog2(WORD_WIDTH);

  logic                  busy_q, done_q, neg_q;
  logic [CntW-1:0]       cnt_q;
  alu_kind_e             kind_q;
  logic [WORD_WIDTH-1:0] rem_q;
  logic [WORD_WIDTH-1:0] quo_q, dvs_q, acc_q;
  logic [WORD_WIDTH-1:0] abs_a, abs_b;
  logic [WORD_WIDTH:0]   rem_sh;
  logic                  fits;

  assign abs_a  = opa_i[WORD_WIDTH-1] ? (~opa_i + 1'b1) : opa_i;
  assign abs_b  = opb_i[WORD_WIDTH-1] ? (~opb_i + 1'b1) : opb_i;
  assign rem_sh = {rem_q, quo_q[WORD_WIDTH-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(WORD_WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      kind_q <= req_i.kind;
      rem_q  <= '0;
      acc_q  <= '0;
      if (req_i.kind == ALU_MUL) begin
        quo_q <= opa_i;
        dvs_q <= opb_i;
        neg_q <= 1'b0;
      end else begin
        quo_q <= abs_b;
        dvs_q <= abs_a;
        neg_q <= (req_i.kind == ALU_DIV) ? (opa_i[WORD_WIDTH-1] ^ opb_i[WORD_WIDTH-1])
                                         : opb_i[WORD_WIDTH-1];
      end
    end else if (busy_q) begin
      if (kind_q == ALU_MUL) begin
        // shift-add, one multiplier bit a cycle
        if (quo_q[0]) acc_q <= acc_q + dvs_q;
        dvs_q <= {dvs_q[WORD_WIDTH-2:0], 1'b0};
        quo_q <= {1'b0, quo_q[WORD_WIDTH-1:1]};
      end else begin
        // restoring division, one quotient bit a cycle
        rem_q <= fits ? WORD_WIDTH'(rem_sh - {1'b0, dvs_q}) : rem_sh[WORD_WIDTH-1:0];
        quo_q <= {quo_q[WORD_WIDTH-2:0], fits};
      end
    end
  end

  always_comb begin
    case (kind_q)
      ALU_MUL: result_o = acc_q;
      ALU_DIV: result_o = neg_q ? (~quo_q + 1'b1) : quo_q;
      default: result_o = neg_q ? (~rem_q + 1'b1) : rem_q;
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- design/forth_stack_machine_core_top.sv -----
// forth stack machine core: token decode, shifting cell stack, serial arithmetic
// sequence: a token is latched in IDLE, decoded in EXEC and its result registered on
//   commit; multiply, divide and modulo wait in ALU for the bit-serial arithmetic unit
// input: a new token is taken only in IDLE, so one token is in flight at a time, and
//   commit waits while the output register still holds an untaken result
// reset: asynchronous, active low; clears stack depth, skip and discard state and
//   the output valid; stack entries hold no reset value and are never read unwritten
`default_nettype none

`include "forth_stack_machine_core_top_assert.svh"

module forth_stack_machine_core_top #(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // opcode [4:0], literal [35:5], zero pad [39:36]
  input  wire  [fsmc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // end_of_line
  input  wire                            s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // top_value [31:0], stack_count [38:32], print_valid [39], print_value [71:40],
  // newline_strobe [72], token_skipped [73], error_code [76:74], zero pad [79:77]
  output logic [fsmc_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import fsmc_pkg::*;

  localparam int SpW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_ALU  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // latched token
  logic [4:0]            op_q;
  logic [30:0]           lit_q;
  logic                  eol_q;

  // control state
  logic [SpW-1:0]        sp_q, sp_d;
  skip_e                 skip_q, skip_d;
  logic                  disc_q, disc_d;

  // result register
  logic                  out_valid_q;
  logic                  pv_q, nl_q, skipped_q;
  logic [31:0]           pval_q;
  logic [2:0]            err_q;

  // stack cells, entry 0 is the top
  logic [WORD_WIDTH-1:0] cell_val [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] c0, c1, lit_w, push_val, load0, load1, arith_r;
  cell_ctrl_t            ctrl, ctrl_g;

  logic                  skipped, pv, nl, go_alu, commit, out_free;
  logic [2:0]            err;
  logic                  need1, need2, grows, is_long, undef;

  alu_req_t              alu_req;
  logic                  alu_done;
  logic [WORD_WIDTH-1:0] alu_res;

  logic [31:0]           c0_32;
  logic [6:0]            count7;

  assign c0 = cell_val[0];
  assign c1 = cell_val[1];

  // literal fitted to the word width, top fitted to 32 bits, depth to 7 bits
  generate
    if (WORD_WIDTH >= 31) begin : g_lit_ext
      assign lit_w = WORD_WIDTH'(lit_q);
    end else begin : g_lit_trunc
      assign lit_w = lit_q[WORD_WIDTH-1:0];
    end
    if (WORD_WIDTH >= 32) begin : g_top_trunc
      assign c0_32 = c0[31:0];
    end else begin : g_top_ext
      assign c0_32 = {{(32 - WORD_WIDTH){c0[WORD_WIDTH-1]}}, c0};
    end
    if (SpW >= 7) begin : g_cnt_trunc
      assign count7 = sp_q[6:0];
    end else begin : g_cnt_ext
      assign count7 = {{(7 - SpW){1'b0}}, sp_q};
    end
  endgenerate

  // operand classes of the latched token
  assign need1   = (op_q == OP_DOT) || (op_q == OP_IF) || (op_q == OP_DUP) ||
                   (op_q == OP_DROP) || (op_q == OP_ZGT) || (op_q == OP_ZLT);
  assign need2   = (op_q >= OP_ADD) && (op_q <= OP_NE);
  assign grows   = (op_q == OP_PUSH) || (op_q == OP_DUP);
  assign is_long = (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_MOD);
  assign undef   = op_q > OP_ZLT;

  // two-operand result, b is the second entry and a the top
  always_comb begin
    unique case (op_q)
      OP_ADD:  arith_r = c1 + c0;
      OP_SUB:  arith_r = c1 - c0;
      OP_GT:   arith_r = WORD_WIDTH'($signed(c1) >  $signed(c0));
      OP_LT:   arith_r = WORD_WIDTH'($signed(c1) <  $signed(c0));
      OP_GE:   arith_r = WORD_WIDTH'($signed(c1) >= $signed(c0));
      OP_LE:   arith_r = WORD_WIDTH'($signed(c1) <= $signed(c0));
      OP_EQ:   arith_r = WORD_WIDTH'(c1 == c0);
      OP_NE:   arith_r = WORD_WIDTH'(c1 != c0);
      default: arith_r = alu_res;
    endcase
  end

  // token decode: skip handling, error checks, stack action
  always_comb begin
    skipped  = 1'b0;
    err      = ERR_NONE;
    pv       = 1'b0;
    nl       = 1'b0;
    sp_d     = sp_q;
    skip_d   = skip_q;
    disc_d   = disc_q;
    ctrl     = '{head: CELL_HOLD, second: CELL_HOLD, rest: CELL_HOLD};
    push_val = lit_w;
    load0    = arith_r;
    load1    = c0;
    if (disc_q) begin
      skipped = 1'b1;
    end else if (skip_q != SKIP_NONE) begin
      skipped = 1'b1;
      // unnested: the first THEN, or ELSE after a false IF, ends the skip
      if (op_q == OP_THEN || (skip_q == SKIP_IF && op_q == OP_ELSE)) skip_d = SKIP_NONE;
    end else if (undef) begin
      err = ERR_UNDEF;
    end else if ((need1 && sp_q == '0) || (need2 && sp_q < SpW'(2))) begin
      err = ERR_UNDER;
    end else if (grows && sp_q == SpW'(STACK_DEPTH)) begin
      err = ERR_OVER;
    end else if ((op_q == OP_DIV || op_q == OP_MOD) && c0 == '0) begin
      err = ERR_DIVZ;
    end else begin
      unique case (op_q)
        OP_PUSH: begin
          ctrl = '{head: CELL_PUSH, second: CELL_PUSH, rest: CELL_PUSH};
          sp_d = sp_q + 1'b1;
        end
        OP_CR: nl = 1'b1;
        OP_DOT: begin
          pv   = 1'b1;
          ctrl = '{head: CELL_POP, second: CELL_POP, rest: CELL_POP};
          sp_d = sp_q - 1'b1;
        end
        OP_IF: begin
          if (c0 == '0) skip_d = SKIP_IF;
          ctrl = '{head: CELL_POP, second: CELL_POP, rest: CELL_POP};
          sp_d = sp_q - 1'b1;
        end
        OP_ELSE: skip_d = SKIP_ELSE;
        OP_DUP: begin
          push_val = c0;
          ctrl     = '{head: CELL_PUSH, second: CELL_PUSH, rest: CELL_PUSH};
          sp_d     = sp_q + 1'b1;
        end
        OP_DROP: begin
          ctrl = '{head: CELL_POP, second: CELL_POP, rest: CELL_POP};
          sp_d = sp_q - 1'b1;
        end
        OP_SWAP: begin
          load0 = c1;
          ctrl  = '{head: CELL_LOAD, second: CELL_LOAD, rest: CELL_HOLD};
        end
        OP_ZGT: begin
          load0 = WORD_WIDTH'($signed(c0) > $signed(WORD_WIDTH'(0)));
          ctrl  = '{head: CELL_LOAD, second: CELL_HOLD, rest: CELL_HOLD};
        end
        OP_ZLT: begin
          load0 = WORD_WIDTH'(c0[WORD_WIDTH-1]);
          ctrl  = '{head: CELL_LOAD, second: CELL_HOLD, rest: CELL_HOLD};
        end
        OP_THEN: ;
        default: begin
          // two-operand ops: result loads the top entry, the rest pop up, stack drops by one
          ctrl = '{head: CELL_LOAD, second: CELL_POP, rest: CELL_POP};
          sp_d = sp_q - 1'b1;
        end
      endcase
    end
    if (err != ERR_NONE) disc_d = 1'b1;
    if (eol_q) begin
      skip_d = SKIP_NONE;
      disc_d = 1'b0;
    end
  end

  // sequencing: decode in EXEC, long ops wait on the serial unit
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign go_alu   = (state_q == S_EXEC) && !skipped && (err == ERR_NONE) && is_long;
  assign commit   = out_free && (((state_q == S_EXEC) && !go_alu) ||
                                 ((state_q == S_ALU) && alu_done));

  assign alu_req.start = go_alu;
  assign alu_req.kind  = (op_q == OP_MUL) ? ALU_MUL : (op_q == OP_DIV) ? ALU_DIV : ALU_MOD;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (go_alu) state_d = S_ALU;
        else if (commit) state_d = S_IDLE;
      end
      S_ALU: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      skip_q      <= SKIP_NONE;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        sp_q   <= sp_d;
        skip_q <= skip_d;
        disc_q <= disc_d;
      end
      if (commit) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // token and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q  <= s_axis_tdata_i[4:0];
      lit_q <= s_axis_tdata_i[35:5];
      eol_q <= s_axis_tlast_i;
    end
    if (commit) begin
      pv_q      <= pv;
      pval_q    <= pv ? c0_32 : '0;
      nl_q      <= nl;
      skipped_q <= skipped;
      err_q     <= err;
    end
  end

  // cells only move on commit
  assign ctrl_g = commit ? ctrl : '{head: CELL_HOLD, second: CELL_HOLD, rest: CELL_HOLD};

  generate
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      cell_cmd_e             cmd;
      logic [WORD_WIDTH-1:0] up, down, ld;
      if (i == 0) begin : g_head
        assign cmd = ctrl_g.head;
        assign up  = push_val;
        assign ld  = load0;
      end else if (i == 1) begin : g_second
        assign cmd = ctrl_g.second;
        assign up  = cell_val[0];
        assign ld  = load1;
      end else begin : g_rest
        assign cmd = ctrl_g.rest;
        assign up  = cell_val[i-1];
        assign ld  = cell_val[i];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
        assign down = '0;
      end else begin : g_inner
        assign down = cell_val[i+1];
      end
      fsmc_stack_cell #(
        .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .cmd_i   (cmd),
        .up_i    (up),
        .down_i  (down),
        .load_i  (ld),
        .value_o (cell_val[i])
      );
    end
  endgenerate

  fsmc_serial_alu #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .opa_i    (c0),
    .opb_i    (c1),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, err_q, skipped_q, nl_q, pval_q, pv_q, count7,
                            (sp_q != '0) ? c0_32 : 32'd0};

  `FSMC_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= SpW'(STACK_DEPTH), "stack depth beyond capacity")
  `FSMC_ASSERT_IMP(a_alu_start, alu_req.start, state_q == S_EXEC && !skipped, "alu start outside decode")
  `FSMC_ASSERT_NXT(a_commit_out, commit, out_valid_q && state_q == S_IDLE, "commit without result")
  `FSMC_ASSERT_IMP(a_err_keeps_sp, commit && err != ERR_NONE, sp_d == sp_q, "failed token moved the stack")

endmodule

`default_nettype wire
